// File: rtl/core/plc_tb_pkg.sv
// Shared types and constants of the PLC timer bank.
`default_nettype none

package plc_tb_pkg;

  localparam int NUM_TIMERS    = 64;
  localparam int IDX_W         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MS_PER_SECOND = 1000;
  localparam int DELAY_W       = 20;
  localparam int ELAPSED_W     = 20;
  localparam int ID_W          = 6;
  localparam int PRESET_W      = 30;
  localparam int COUNT_W       = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Command codes on s_tuser
  localparam logic [1:0] CMD_CYCLE   = 2'd0;
  localparam logic [1:0] CMD_ON_DLY  = 2'd1;
  localparam logic [1:0] CMD_OFF_DLY = 2'd2;
  localparam logic [1:0] CMD_ONESHOT = 2'd3;

  // Item kinds after classification
  localparam logic [1:0] KIND_CYCLE = 2'd0;
  localparam logic [1:0] KIND_EVAL  = 2'd1;
  localparam logic [1:0] KIND_NOP   = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           cmd;
    logic                 start;
    logic [PRESET_W-1:0]  preset;
    logic [IDX_W-1:0]     idx;
    logic [ELAPSED_W-1:0] elapsed;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/core/plc_timer_bank_unit.sv
// Items pass the queue, the cur register and the result register; a busy output holds cur.
// The back end pops no new item until the last one has read, then written the count memory.
// A two-entry queue lets input be accepted while a result waits on the output.
// Reset: synchronous rst clears queue, control and the per-timer valid and touched bits
// at once; all counts then read as zero, and no clearing pass is needed.
`default_nettype none

module plc_timer_bank_unit import plc_tb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // start_req, unit_seconds, delay[19:0], timer_id[5:0],
                                     // elapsed_ms[19:0]
  input  wire logic [1:0]  s_tuser,  // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata   // timer_out, zero padding[7:1]
);

  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  q_full;
  logic  q_empty;

  plc_tb_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  plc_tb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  plc_tb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/plc_tb_front.sv
// Front end: accepts items, scales the preset and classifies the command.
`default_nettype none

module plc_tb_front import plc_tb_pkg::*; (
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // start_req, unit_seconds, delay[19:0], timer_id[5:0],
                                     // elapsed_ms[19:0]
  input  wire logic [1:0]  s_tuser,  // cmd[1:0]
  input  wire logic        q_full,
  output logic             push,
  output item_t            push_item
);

  logic                 start_req;
  logic                 unit_seconds;
  logic [DELAY_W-1:0]   delay;
  logic [ID_W-1:0]      timer_id;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [PRESET_W-1:0]  scaled;
  logic                 in_range;

  assign start_req    = s_tdata[0];
  assign unit_seconds = s_tdata[1];
  assign delay        = s_tdata[21:2];
  assign timer_id     = s_tdata[27:22];
  assign elapsed_ms   = s_tdata[47:28];

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  assign scaled   = PRESET_W'(delay) * PRESET_W'(MS_PER_SECOND);
  assign in_range = 32'(timer_id) < 32'(NUM_TIMERS);

  always_comb begin
    push_item.cmd     = s_tuser;
    push_item.start   = start_req;
    push_item.preset  = unit_seconds ? scaled : PRESET_W'(delay);
    push_item.idx     = IDX_W'(timer_id);
    push_item.elapsed = elapsed_ms;
    if (s_tuser == CMD_CYCLE) begin
      push_item.kind = KIND_CYCLE;
    end else if (in_range) begin
      push_item.kind = KIND_EVAL;
    end else begin
      push_item.kind = KIND_NOP;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/plc_tb_queue.sv
// Short queue of classified items between front and back.
`default_nettype none

module plc_tb_queue import plc_tb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/plc_tb_back.sv
// Back end: read-modify-write of the timer counts and the result register.
`default_nettype none

module plc_tb_back import plc_tb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire item_t      head,
  input  wire logic       empty,
  output logic            pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata   // timer_out, zero padding[7:1]
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state;
  item_t                cur;
  logic [COUNT_W-1:0]   cnt_mem [NUM_TIMERS];
  logic [COUNT_W-1:0]   rd_data;
  logic [NUM_TIMERS-1:0] valid;
  logic [NUM_TIMERS-1:0] touched;
  logic [ELAPSED_W-1:0] last_elapsed;
  logic                 out_bit;

  logic                 exec_fire;
  logic [COUNT_W-1:0]   cnt_cur;
  logic [COUNT_W:0]     sum;
  logic [COUNT_W-1:0]   sum_sat;
  logic [COUNT_W-1:0]   preset_w;
  logic [COUNT_W-1:0]   elapsed_w;
  logic [COUNT_W-1:0]   cnt_new;
  logic                 res;

  assign pop       = (state == ST_IDLE) && !empty;
  assign exec_fire = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign m_tdata   = {7'b0, out_bit};

  // Never-written entries read as zero through the valid bits
  assign cnt_cur   = valid[cur.idx] ? rd_data : '0;
  assign elapsed_w = COUNT_W'(last_elapsed);
  assign preset_w  = COUNT_W'(cur.preset);
  assign sum       = {1'b0, cnt_cur} + {1'b0, elapsed_w};
  assign sum_sat   = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

  always_comb begin
    cnt_new = cnt_cur;
    res     = 1'b0;
    case (cur.cmd)
      CMD_OFF_DLY: begin
        if (cur.start) begin
          cnt_new = preset_w;
          res     = 1'b1;
        end else if (cnt_cur != '0) begin
          res     = 1'b1;
          cnt_new = (cnt_cur > elapsed_w) ? cnt_cur - elapsed_w : '0;
        end
      end
      CMD_ON_DLY, CMD_ONESHOT: begin
        if (cur.start) begin
          cnt_new = sum_sat;
          if (sum_sat >= preset_w) begin
            res = 1'b1;
            if (cur.cmd == CMD_ONESHOT) begin
              cnt_new = '0;
            end
          end
        end else begin
          cnt_new = '0;
        end
      end
      default: begin
        cnt_new = cnt_cur;
        res     = 1'b0;
      end
    endcase
  end

  // Count memory: read on pop, write back on execute of an evaluate item
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= cnt_mem[head.idx];
    end
    if (exec_fire && cur.kind == KIND_EVAL) begin
      cnt_mem[cur.idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (exec_fire) begin
      out_bit <= (cur.kind == KIND_EVAL) ? res : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      valid        <= '0;
      touched      <= '0;
      last_elapsed <= '0;
    end else begin
      if (pop) begin
        state <= ST_EXEC;
      end else if (exec_fire) begin
        state <= ST_IDLE;
      end
      if (exec_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (exec_fire && cur.kind == KIND_CYCLE) begin
        // Drop counts of timers not evaluated since the last cycle
        last_elapsed <= cur.elapsed;
        valid        <= valid & touched;
        touched      <= '0;
      end else if (exec_fire && cur.kind == KIND_EVAL) begin
        valid[cur.idx]   <= 1'b1;
        touched[cur.idx] <= 1'b1;
      end
    end
  end

  a_touched_valid: assert property (@(posedge clk) disable iff (rst)
    (touched & ~valid) == '0)
    else $error("touched timer without a valid count");

  a_cycle_clears: assert property (@(posedge clk) disable iff (rst)
    exec_fire && cur.kind == KIND_CYCLE |=> touched == '0)
    else $error("cycle item left touched marks set");

  a_eval_marks: assert property (@(posedge clk) disable iff (rst)
    exec_fire && cur.kind == KIND_EVAL |=> valid[$past(cur.idx)] && touched[$past(cur.idx)])
    else $error("evaluated timer not marked");

  a_exec_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && m_tvalid && !m_tready |=> state == ST_EXEC)
    else $error("execute step overwrote a waiting result");

endmodule

`default_nettype wire
